// File: design/pwmpd_pkg.sv
// Shared types and constants for the PWM period and duty detector.
`timescale 1ns / 1ps
`default_nettype none

package pwmpd_pkg;

    localparam int COUNT_WIDTH_DEF = 31;
    localparam int RATE_W          = 27;
    localparam int OUT_CNT_W       = 31;
    localparam int DUTY_W          = 7;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 96;
    localparam int FREQ_STEPS      = 27;
    localparam int DUTY_STEPS      = 7;
    localparam int STEP_W          = 5;
    localparam int SHIFT_W         = 3;

    localparam logic [RATE_W-1:0]    RATE_RESET  = 27'd40000;
    localparam logic [DUTY_W-1:0]    DUTY_SCALE  = 7'd100;
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_FREQ,
        ST_DUTY,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic               accept;
        logic               prep;
        logic               freq_step;
        logic               duty_step;
        logic               out_load;
        logic [SHIFT_W-1:0] shift;
    } t_dp_cmd;

    typedef struct packed {
        logic is_edge;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: design/pwmpd_ctrl.sv
// Controller: sequences edge capture, frequency and duty division, and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module pwmpd_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    output logic                o_s_tready,
    input  pwmpd_pkg::t_dp_stat i_stat,
    output pwmpd_pkg::t_dp_cmd  o_cmd
);
    import pwmpd_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && i_stat.is_edge) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_FREQ;
                n_step  = '0;
            end
            ST_FREQ: begin
                if (r_step == STEP_W'(FREQ_STEPS - 1)) begin
                    n_state = ST_DUTY;
                    n_step  = STEP_W'(DUTY_STEPS - 1);
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DUTY: begin
                if (r_step == '0) begin
                    n_state = ST_HOLD;
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end
            ST_HOLD: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready      = 1'b0;
        o_cmd           = '0;
        o_cmd.shift     = r_step[SHIFT_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            ST_PREP: o_cmd.prep      = 1'b1;
            ST_FREQ: o_cmd.freq_step = 1'b1;
            ST_DUTY: o_cmd.duty_step = 1'b1;
            ST_HOLD: o_cmd.out_load  = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_edge_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_stat.is_edge) |=> (r_state == ST_PREP))
        else $error("edge beat did not start a division");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("result loaded over a waiting result");

    a_duty_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUTY) |-> (r_step <= STEP_W'(DUTY_STEPS - 1)))
        else $error("duty step index out of range");

endmodule

`default_nettype wire

// File: design/pwmpd_dp.sv
// Datapath: run counter, held counts, shared shift-subtract divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module pwmpd_dp #(
    parameter int COUNT_WIDTH = pwmpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  pwmpd_pkg::t_dp_cmd                     i_cmd,
    output pwmpd_pkg::t_dp_stat                    o_stat,
    input  wire                                    i_level,
    input  wire                                    i_cfg_valid,
    input  wire [pwmpd_pkg::RATE_W-1:0]            i_cfg_data,
    output logic                                   o_m_tvalid,
    input  wire                                    i_m_tready,
    output logic [pwmpd_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                   o_m_tuser
);
    import pwmpd_pkg::*;

    localparam int SW = COUNT_WIDTH + 2;   // period sum and frequency remainder
    localparam int NW = COUNT_WIDTH + 7;   // scaled high count for the duty
    localparam int RW = COUNT_WIDTH + 8;   // subtractor operand width
    localparam int XW = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

    logic [RATE_W-1:0]      r_rate;
    logic [COUNT_WIDTH-1:0] r_run, r_held_hi, r_held_lo;
    logic                   r_prev;
    logic [SW-1:0]          r_sum, r_rem;
    logic [NW-1:0]          r_num;
    logic [RATE_W-1:0]      r_dvd;
    logic [DUTY_W-1:0]      r_duty;
    logic                   r_out_valid;
    logic [OUT_CNT_W-1:0]   r_o_hi, r_o_lo;
    logic [RATE_W-1:0]      r_o_freq;
    logic [DUTY_W-1:0]      r_o_duty;
    logic                   r_o_kind;

    logic [SW:0]            freq_t;
    logic [RW-1:0]          sub_a, sub_b;
    logic [RW:0]            sub_d;
    logic                   sub_ge;
    logic [XW-1:0]          hi_x, lo_x;
    logic [OUT_CNT_W-1:0]   hi_clip, lo_clip;
    logic                   is_edge;

    assign is_edge = (i_level != r_prev);

    // one subtractor serves both divisions
    always_comb begin
        freq_t = {r_rem, r_dvd[RATE_W-1]};
        if (i_cmd.freq_step) begin
            sub_a = RW'(freq_t);
            sub_b = RW'(r_sum);
        end else begin
            sub_a = RW'(r_num);
            sub_b = RW'(r_sum) << i_cmd.shift;
        end
        sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = !sub_d[RW];
    end

    always_comb begin
        hi_x    = XW'(r_held_hi);
        lo_x    = XW'(r_held_lo);
        hi_clip = (hi_x > XW'(OUT_CNT_MAX)) ? OUT_CNT_MAX : hi_x[OUT_CNT_W-1:0];
        lo_clip = (lo_x > XW'(OUT_CNT_MAX)) ? OUT_CNT_MAX : lo_x[OUT_CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= RATE_RESET;
            r_run       <= '0;
            r_prev      <= 1'b0;
            r_held_hi   <= '0;
            r_held_lo   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_rate <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (is_edge) begin
                    if (i_level) begin
                        r_held_lo <= r_run;
                    end else begin
                        r_held_hi <= r_run;
                    end
                    r_prev <= i_level;
                    r_run  <= '0;
                end else if (r_run != '1) begin
                    r_run <= r_run + COUNT_WIDTH'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_sum  <= SW'(r_held_hi) + SW'(r_held_lo) + SW'(2);
            r_num  <= NW'(COUNT_WIDTH'(r_held_hi) + (COUNT_WIDTH+1)'(1)) * NW'(DUTY_SCALE);
            r_rem  <= '0;
            r_dvd  <= r_rate;
            r_duty <= '0;
        end
        if (i_cmd.freq_step) begin
            r_rem <= sub_ge ? sub_d[SW-1:0] : freq_t[SW-1:0];
            r_dvd <= {r_dvd[RATE_W-2:0], sub_ge};
        end
        if (i_cmd.duty_step) begin
            if (sub_ge) begin
                r_num <= sub_d[NW-1:0];
            end
            r_duty <= {r_duty[DUTY_W-2:0], sub_ge};
        end
        if (i_cmd.out_load) begin
            r_o_hi   <= hi_clip;
            r_o_lo   <= lo_clip;
            r_o_freq <= r_dvd;
            r_o_duty <= r_duty;
            r_o_kind <= r_prev;
        end
    end

    assign o_stat.is_edge  = is_edge;
    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tuser       = r_o_kind;
    assign o_m_tdata       = {r_o_duty, r_o_freq, r_o_lo, r_o_hi};

    a_sum_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.freq_step |-> (r_sum >= SW'(2)))
        else $error("period sum below two");

    a_duty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (r_duty <= DUTY_SCALE))
        else $error("duty above one hundred percent");

    a_freq_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (r_dvd <= r_rate))
        else $error("frequency above sample rate");

endmodule

`default_nettype wire

// File: design/pwm_period_duty_detector.sv
// Top level of the PWM period and duty detector.
// Usage:
//   Slave stream (i_s_*): one beat per sample tick, tdata bit 0 is the sampled
//   PWM level. A beat without a level change is taken while idle and only
//   advances the saturating run counter.
//   A level change closes a high or low run and starts a measurement: the
//   frequency quotient comes from a shift-subtract divider, one bit per cycle,
//   then the seven duty bits come from the same subtractor.
//   An edge beat occupies the block through the prep, frequency, duty and
//   hold states; once its result is loaded, the next beat can be taken.
//   Master stream (o_m_*): one result beat per edge. tuser carries the edge
//   kind (1 rising, 0 falling). The output register holds a finished result
//   while the next samples are taken; a stalled receiver keeps the next edge's
//   result in the hold state, with tready low until the register frees.
//   Config channel (i_cfg_*): sample rate in hertz, taken any cycle; write it
//   only while no measurement is running.
//   Reset (synchronous, active low) clears counters and held counts, sets the
//   previous level low and the sample rate to 40000.
`timescale 1ns / 1ps
`default_nettype none

module pwm_period_duty_detector #(
    parameter int COUNT_WIDTH = pwmpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire [pwmpd_pkg::IN_TDATA_W-1:0]    i_s_tdata,   // [0] pwm_level, [7:1] zero
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // [30:0] high_samples, [61:31] low_samples, [88:62] frequency_hz, [95:89] duty_percent
    output logic [pwmpd_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                               o_m_tuser,   // [0] edge_kind
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [pwmpd_pkg::RATE_W-1:0]        i_cfg_data   // sample_rate_hz
);
    import pwmpd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    pwmpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pwmpd_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_level     (i_s_tdata[0]),
        .i_cfg_valid (cfg_wr),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

// File: tb/pwmpd_checker.sv
// Checker for the PWM period and duty detector: predicts edge measurements and compares.
`timescale 1ns / 1ps

module pwmpd_checker #(
    parameter int COUNT_WIDTH = pwmpd_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_tvalid,
    input  wire                                i_s_tready,
    input  wire [pwmpd_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    input  wire                                i_m_tvalid,
    input  wire                                i_m_tready,
    input  wire [pwmpd_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    input  wire                                i_m_tuser,
    input  wire                                i_cfg_valid,
    input  wire                                i_cfg_ready,
    input  wire [pwmpd_pkg::RATE_W-1:0]        i_cfg_data,
    output int                                 o_mismatches,
    output int                                 o_pending,
    output int                                 o_results
);

    import pwmpd_pkg::*;

    typedef struct packed {
        logic                 edge_kind;
        logic [OUT_CNT_W-1:0] high_cnt;
        logic [OUT_CNT_W-1:0] low_cnt;
        logic [RATE_W-1:0]    freq_hz;
        logic [DUTY_W-1:0]    duty_pct;
    } t_edge_meas;

    t_edge_meas             meas_q[$];
    logic [COUNT_WIDTH-1:0] run_cnt;
    logic [COUNT_WIDTH-1:0] held_hi;
    logic [COUNT_WIDTH-1:0] held_lo;
    logic                   prev_lvl;
    logic [RATE_W-1:0]      rate_hz;
    int                     mismatch_cnt = 0;
    int                     result_cnt   = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_results    = result_cnt;
    assign o_pending    = meas_q.size();

    task automatic flag_beat(input string what, input t_edge_meas want, input t_edge_meas got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t checker: %s", $realtime, what);
            $display("    exp kind=%0d high=%0d low=%0d freq=%0d duty=%0d",
                     want.edge_kind, want.high_cnt, want.low_cnt, want.freq_hz, want.duty_pct);
            $display("    got kind=%0d high=%0d low=%0d freq=%0d duty=%0d",
                     got.edge_kind, got.high_cnt, got.low_cnt, got.freq_hz, got.duty_pct);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_edge_meas  want;
        t_edge_meas  got;
        logic [63:0] hi_len;
        logic [63:0] period_len;
        logic        lvl;
        if (!i_rst_n) begin
            run_cnt  = '0;
            held_hi  = '0;
            held_lo  = '0;
            prev_lvl = 1'b0;
            rate_hz  = RATE_RESET;
            meas_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                rate_hz = i_cfg_data;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.edge_kind = i_m_tuser;
                got.high_cnt  = i_m_tdata[30:0];
                got.low_cnt   = i_m_tdata[61:31];
                got.freq_hz   = i_m_tdata[88:62];
                got.duty_pct  = i_m_tdata[95:89];
                result_cnt++;
                if (meas_q.size() == 0) begin
                    flag_beat("result beat with nothing expected", '0, got);
                end else begin
                    want = meas_q.pop_front();
                    if (got !== want) begin
                        flag_beat("result beat mismatch", want, got);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                lvl = i_s_tdata[0];
                if (lvl == prev_lvl) begin
                    // saturate, never wrap
                    if (run_cnt != '1) begin
                        run_cnt = run_cnt + 1'b1;
                    end
                end else begin
                    if (lvl) begin
                        held_lo = run_cnt;
                    end else begin
                        held_hi = run_cnt;
                    end
                    prev_lvl   = lvl;
                    run_cnt    = '0;
                    hi_len     = 64'(held_hi) + 64'd1;
                    period_len = hi_len + 64'(held_lo) + 64'd1;
                    want.edge_kind = lvl;
                    want.high_cnt  = (64'(held_hi) > 64'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                                       : OUT_CNT_W'(held_hi);
                    want.low_cnt   = (64'(held_lo) > 64'(OUT_CNT_MAX)) ? OUT_CNT_MAX
                                                                       : OUT_CNT_W'(held_lo);
                    want.freq_hz   = RATE_W'(64'(rate_hz) / period_len);
                    want.duty_pct  = DUTY_W'((64'(DUTY_SCALE) * hi_len) / period_len);
                    meas_q.push_back(want);
                end
            end
        end
    end

endmodule

// File: tb/tb_top.sv
// Testbench top for the PWM period and duty detector: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_top;

    import pwmpd_pkg::*;

    localparam int LIMIT_CYCLES    = 500000;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 45;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int NUM_PHASES      = 5;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [RATE_W-1:0]      cfg_data  = '0;

    int mismatches;
    int pending;
    int results;
    int beats       = 0;
    int rate_writes = 0;
    int longest_run = 0;
    bit idle_on     = 1'b1;
    bit hold_go     = 1'b0;
    bit hold_done   = 1'b0;
    int hold_left   = 0;
    int stall_left  = 0;

    pwm_period_duty_detector #(
        .COUNT_WIDTH (COUNT_WIDTH_DEF)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    pwmpd_checker #(
        .COUNT_WIDTH (COUNT_WIDTH_DEF)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", LIMIT_CYCLES, pending);
        $display("tb_top: errors");
        $finish;
    end

    // Receiver: random short stalls, plus one long hold to back up the block.
    always @(negedge clk) begin
        if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6);
            end
        end
    end

    task automatic send_level(input logic lvl);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, lvl};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        beats++;
    endtask

    // Wait for every result, then give the divider time to finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        rate_writes++;
    endtask

    initial begin : stimulus
        logic [13:0]       directed_lvls;
        logic              lvl;
        int                run_len;
        int                sent;
        logic [RATE_W-1:0] phase_rate;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // High first after reset is a rising edge; then runs of one and several samples.
        directed_lvls = 14'b01101000111101;
        for (int i = 0; i < 14; i++) begin
            send_level(directed_lvls[i]);
        end
        settle();
        // Zero rate gives zero frequency.
        write_rate('0);
        send_level(1'b1);
        send_level(1'b0);
        send_level(1'b0);
        send_level(1'b1);
        settle();
        write_rate(RATE_W'(1));
        send_level(1'b0);
        send_level(1'b0);
        send_level(1'b1);
        settle();
        write_rate('1);
        send_level(1'b0);
        send_level(1'b1);
        send_level(1'b0);

        lvl = 1'b0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: phase_rate = RATE_W'(100000000);
                1: phase_rate = RATE_W'($urandom_range(1, 100000000));
                2: phase_rate = '1;
                3: phase_rate = RATE_W'($urandom);
                default: phase_rate = RATE_RESET;
            endcase
            write_rate(phase_rate);
            // No idling on either side in the last phase.
            if (phase == NUM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                lvl = ~lvl;
                case ($urandom_range(0, 9))
                    0:       run_len = $urandom_range(40, 250);
                    1, 2:    run_len = $urandom_range(9, 30);
                    default: run_len = $urandom_range(1, 8);
                endcase
                if (run_len > longest_run) begin
                    longest_run = run_len;
                end
                for (int k = 0; k < run_len && sent < ITEMS_PER_PHASE; k++) begin
                    send_level(lvl);
                    sent++;
                    if (phase == 1 && sent == 50) begin
                        hold_go = 1'b1;
                    end
                end
            end
        end
        settle();

        $display("summary: %0d sample beats, %0d edge results, %0d rate writes incl. 0 and max",
                 beats, results, rate_writes);
        $display("summary: runs up to %0d samples, one %0d-cycle receiver hold, idle-free tail",
                 longest_run, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("%0d mismatching beats", mismatches);
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/pwmpd_pkg.sv
design/pwmpd_ctrl.sv
design/pwmpd_dp.sv
design/pwm_period_duty_detector.sv
tb/pwmpd_checker.sv
tb/tb_top.sv
